>>> hw/rtl/plfa_pkg.sv
// Shared types and constants for the pixel table and feather alpha block.
// Used by plfa_pos, pixel_lut_and_feather_alpha_top and plfa_checker.
`default_nettype none

package plfa_pkg;

  localparam int BORDER_WIDTH  = 32;
  localparam int MAX_DIMENSION = 4096;

  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int COUNT_W = $clog2(MAX_DIMENSION);
  localparam int PIX_W   = 8;
  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRECT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  localparam logic [1:0] TABLE_BLUE  = 2'd0;
  localparam logic [1:0] TABLE_GREEN = 2'd1;
  localparam logic [1:0] TABLE_RED   = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);
  localparam logic [PIX_W-1:0] RAMP_STEP = PIX_W'(255 / BORDER_WIDTH);

  // Position-derived info for the pixel currently at the input.
  typedef struct packed {
    logic             in_border;
    logic [PIX_W-1:0] ramp;
    logic             eof;
  } pos_info_t;

endpackage

`default_nettype wire

>>> hw/rtl/plfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plfa_pos.sv
// Raster position counters, edge distance, feather ramp and end-of-frame flag.
// Depends on plfa_pkg.
`default_nettype none

module plfa_pos (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic                      restart,
  input  wire logic [plfa_pkg::DIM_W-1:0] frame_width,
  input  wire logic [plfa_pkg::DIM_W-1:0] frame_height,
  output      plfa_pkg::pos_info_t        info
);

  import plfa_pkg::*;

  logic [COUNT_W-1:0] row;
  logic [COUNT_W-1:0] column;
  logic [COUNT_W-1:0] row_next;
  logic [COUNT_W-1:0] column_next;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] row_ext;
  logic [DIM_W-1:0] col_ext;
  logic [DIM_W-1:0] row_rem;
  logic [DIM_W-1:0] col_rem;
  logic [DIM_W-1:0] min_row;
  logic [DIM_W-1:0] min_col;
  logic [DIM_W-1:0] edge_dist;
  logic [2*PIX_W-1:0] ramp_prod;
  logic             last_col;
  logic             last_row;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  always_comb begin
    w_eff     = clamp_dim(frame_width);
    h_eff     = clamp_dim(frame_height);
    row_ext   = DIM_W'(row);
    col_ext   = DIM_W'(column);
    row_rem   = h_eff - row_ext;
    col_rem   = w_eff - col_ext;
    min_row   = (row_ext < row_rem) ? row_ext : row_rem;
    min_col   = (col_ext < col_rem) ? col_ext : col_rem;
    edge_dist = (min_row < min_col) ? min_row : min_col;

    ramp_prod = (2*PIX_W)'(edge_dist[PIX_W-1:0]) * (2*PIX_W)'(PIX_MAX);
    info.in_border = (edge_dist <= DIM_W'(BORDER_WIDTH));
    info.ramp      = PIX_W'(ramp_prod / BORDER_WIDTH);

    last_col = ((col_ext + DIM_W'(1)) >= w_eff);
    last_row = ((row_ext + DIM_W'(1)) >= h_eff);
    info.eof = last_col & last_row;

    row_next    = row;
    column_next = column;
    if (restart) begin
      row_next    = '0;
      column_next = '0;
    end else if (advance) begin
      if (last_col) begin
        column_next = '0;
        row_next    = last_row ? '0 : row + COUNT_W'(1);
      end else begin
        column_next = column + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      column <= '0;
    end else begin
      row    <= row_next;
      column <= column_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pixel_lut_and_feather_alpha_top.sv
// Pixel colour correction and feather alpha: top level.
// Depends on plfa_pkg, plfa_ram and plfa_pos.
//
// One item per clock through two register stages while the input is not stalled: a pixel
// beat accepted at the input is held in stage 1 and then moves into the output register;
// a stalled output holds its result, and with stage 1 full also stalls the input. Each pixel is
// looked up in three 256-entry colour tables (registered read in the first stage) and the
// result is selected in the second; table write beats are taken at the same rate and
// produce no result. The edge distance and feather ramp come from the row/column counters
// at the input. Table entries hold garbage until written. Write correct_enable,
// frame_width and frame_height only while the block is idle; a write to either dimension
// restarts the frame at row 0, column 0.
`default_nettype none

module pixel_lut_and_feather_alpha_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write channel
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [plfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [plfa_pkg::DIM_W-1:0]     cfg_data,
  // input item channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          command,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic [7:0]                    mask_level,
  input  wire logic [1:0]                    table_select,
  input  wire logic [7:0]                    table_index,
  input  wire logic [7:0]                    table_value,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [7:0]                    out_red,
  output      logic [7:0]                    out_green,
  output      logic [7:0]                    out_blue,
  output      logic [7:0]                    front_alpha,
  output      logic [7:0]                    back_alpha,
  output      logic                          end_of_frame
);

  import plfa_pkg::*;

  logic             correct_enable;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  logic cfg_write;
  logic restart;
  logic accept;
  logic pix_accept;
  logic tbl_write;

  pos_info_t pos_info;

  logic [PIX_W-1:0] lut_red;
  logic [PIX_W-1:0] lut_green;
  logic [PIX_W-1:0] lut_blue;

  // stage 1: table read in flight
  logic             s1_valid;
  logic [PIX_W-1:0] s1_red;
  logic [PIX_W-1:0] s1_green;
  logic [PIX_W-1:0] s1_blue;
  logic [PIX_W-1:0] s1_mask;
  pos_info_t        s1_pos;
  logic             s1_move;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign restart   = cfg_write &
                     ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      correct_enable <= 1'b0;
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CORRECT_ENABLE: correct_enable <= cfg_data[0];
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data;
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Hold the input only when stage 1 is full and cannot drain.
  assign s1_move    = s1_valid & (~out_valid | ~out_stall);
  assign in_stall   = s1_valid & out_valid & out_stall;
  assign accept     = in_valid & ~in_stall;
  assign pix_accept = accept & (command == CMD_PIXEL);
  assign tbl_write  = accept & (command == CMD_TABLE);

  plfa_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (pix_accept),
    .restart      (restart),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .info         (pos_info)
  );

  plfa_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_tbl_red (
    .clk     (clk),
    .wr_en   (tbl_write & (table_select == TABLE_RED)),
    .wr_addr (table_index),
    .wr_data (table_value),
    .rd_en   (pix_accept),
    .rd_addr (red),
    .rd_data (lut_red)
  );

  plfa_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_tbl_green (
    .clk     (clk),
    .wr_en   (tbl_write & (table_select == TABLE_GREEN)),
    .wr_addr (table_index),
    .wr_data (table_value),
    .rd_en   (pix_accept),
    .rd_addr (green),
    .rd_data (lut_green)
  );

  plfa_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_tbl_blue (
    .clk     (clk),
    .wr_en   (tbl_write & (table_select == TABLE_BLUE)),
    .wr_addr (table_index),
    .wr_data (table_value),
    .rd_en   (pix_accept),
    .rd_addr (blue),
    .rd_data (lut_blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
      s1_mask  <= mask_level;
      s1_pos   <= pos_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_red      <= correct_enable ? lut_red   : s1_red;
      out_green    <= correct_enable ? lut_green : s1_green;
      out_blue     <= correct_enable ? lut_blue  : s1_blue;
      front_alpha  <= s1_mask;
      back_alpha   <= s1_pos.in_border ? s1_pos.ramp : PIX_MAX - s1_mask;
      end_of_frame <= s1_pos.eof;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/plfa_checker.sv
// Port-level checks for pixel_lut_and_feather_alpha_top, bound to the top level.
// Depends on plfa_pkg.
`default_nettype none

module plfa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] front_alpha,
  input wire logic [7:0] back_alpha,
  input wire logic       end_of_frame
);

  import plfa_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({out_red, out_green, out_blue,
                                                     front_alpha, back_alpha, end_of_frame}))
    else $error("stalled result beat changed");

  // Input backpressure only comes from a stalled, full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without downstream stall");

  // Last pixel sits next to the right edge, so it is always on the ramp.
  a_eof_ramp: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> back_alpha == '0 || back_alpha == RAMP_STEP)
    else $error("end of frame outside the feather ramp");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pixel_lut_and_feather_alpha_top plfa_checker u_plfa_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for pixel_lut_and_feather_alpha_top: table correction, feather alpha.
// A scoreboard class predicts each pixel beat from its own copy of tables, counters and
// registers; depends on plfa_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
  import plfa_pkg::*;

  localparam logic [1:0] TABLE_NONE = 2'd3;

  typedef struct {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] mask;
    logic [1:0] sel;
    logic [7:0] idx;
    logic [7:0] value;
  } pixel_beat_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] front;
    logic [7:0] back;
    logic       eof;
  } pixel_out_t;

  class feather_lut_scoreboard;
    logic [7:0] lut [3][256];
    bit         written [3][256];
    int         row_pos;
    int         col_pos;
    int         frame_w;
    int         frame_h;
    bit         correct_on;
    int         errors;
    pixel_out_t pending_pixels[$];

    function new();
      row_pos    = 0;
      col_pos    = 0;
      frame_w    = 640;
      frame_h    = 480;
      correct_on = 1'b0;
      errors     = 0;
    endfunction

    function int fit_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return int'(v);
    endfunction

    function int smaller(int a, int b);
      return (a < b) ? a : b;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_CORRECT_ENABLE: correct_on = data[0];
        CFG_FRAME_WIDTH: begin
          frame_w = fit_dim(data);
          row_pos = 0;
          col_pos = 0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_h = fit_dim(data);
          row_pos = 0;
          col_pos = 0;
        end
        default: ;
      endcase
    endfunction

    // Choose a channel value whose entry in table t holds a known value.
    function logic [7:0] pick_written(int t);
      logic [7:0] v;
      do v = 8'($urandom); while (!written[t][v]);
      return v;
    endfunction

    function void note_beat(pixel_beat_t b);
      pixel_out_t r;
      int         edge_dist;
      if (b.cmd == CMD_TABLE) begin
        if (b.sel != TABLE_NONE) begin
          lut[b.sel][b.idx]     = b.value;
          written[b.sel][b.idx] = 1'b1;
        end
        return;
      end
      r.red   = correct_on ? lut[TABLE_RED][b.red]     : b.red;
      r.green = correct_on ? lut[TABLE_GREEN][b.green] : b.green;
      r.blue  = correct_on ? lut[TABLE_BLUE][b.blue]   : b.blue;
      r.front = b.mask;
      edge_dist = smaller(smaller(row_pos, frame_h - row_pos),
                          smaller(col_pos, frame_w - col_pos));
      if (edge_dist <= BORDER_WIDTH) r.back = 8'((edge_dist * 255) / BORDER_WIDTH);
      else r.back = 8'(255 - int'(b.mask));
      r.eof = 1'b0;
      // advance raster position, wrap at frame end
      if (col_pos + 1 >= frame_w) begin
        col_pos = 0;
        if (row_pos + 1 >= frame_h) begin
          row_pos = 0;
          r.eof   = 1'b1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
      pending_pixels.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want_v, got_v);
      end
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("result beat with no pixel pending");
        return;
      end
      want = pending_pixels.pop_front();
      compare("out_red", want.red, got.red);
      compare("out_green", want.green, got.green);
      compare("out_blue", want.blue, got.blue);
      compare("front_alpha", want.front, got.front);
      compare("back_alpha", want.back, got.back);
      compare("end_of_frame", 8'(want.eof), 8'(got.eof));
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = CMD_PIXEL;
  logic [7:0]           red = '0;
  logic [7:0]           green = '0;
  logic [7:0]           blue = '0;
  logic [7:0]           mask_level = '0;
  logic [1:0]           table_select = '0;
  logic [7:0]           table_index = '0;
  logic [7:0]           table_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic [7:0]           front_alpha;
  logic [7:0]           back_alpha;
  logic                 end_of_frame;

  bit                    steady = 1'b0;
  feather_lut_scoreboard sb = new();

  pixel_lut_and_feather_alpha_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .mask_level   (mask_level),
    .table_select (table_select),
    .table_index  (table_index),
    .table_value  (table_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .front_alpha  (front_alpha),
    .back_alpha   (back_alpha),
    .end_of_frame (end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: check accepted beats, stall at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel('{out_red, out_green, out_blue, front_alpha, back_alpha, end_of_frame});
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 11);
  end

  function automatic pixel_beat_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] m);
    pixel_beat_t p;
    p.cmd   = CMD_PIXEL;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.mask  = m;
    p.sel   = 2'($urandom);
    p.idx   = 8'($urandom);
    p.value = 8'($urandom);
    return p;
  endfunction

  function automatic pixel_beat_t table_write(logic [1:0] sel, logic [7:0] idx,
                                              logic [7:0] value);
    pixel_beat_t p;
    p       = pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    p.cmd   = CMD_TABLE;
    p.sel   = sel;
    p.idx   = idx;
    p.value = value;
    return p;
  endfunction

  function automatic pixel_beat_t random_beat(int write_pct);
    pixel_beat_t p;
    logic [7:0]  m;
    logic [1:0]  sel;
    if ($urandom_range(99) < write_pct) begin
      sel = ($urandom_range(15) == 0) ? TABLE_NONE : 2'($urandom_range(2));
      return table_write(sel, 8'($urandom), 8'($urandom));
    end
    case ($urandom_range(15))
      0: m = 8'h00;
      1: m = 8'hFF;
      default: m = 8'($urandom);
    endcase
    if (sb.correct_on)
      p = pixel(sb.pick_written(TABLE_RED), sb.pick_written(TABLE_GREEN),
                sb.pick_written(TABLE_BLUE), m);
    else
      p = pixel(8'($urandom), 8'($urandom), 8'($urandom), m);
    return p;
  endfunction

  task automatic send_beat(input pixel_beat_t b);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= b.cmd;
    red          <= b.red;
    green        <= b.green;
    blue         <= b.blue;
    mask_level   <= b.mask;
    table_select <= b.sel;
    table_index  <= b.idx;
    table_value  <= b.value;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty; a table write is complete once accepted,
  // and the task also idles before the register writes.
  task automatic configure(input logic [DIM_W-1:0] enable_data,
                           input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
    hold_until_drained();
    repeat (4) @(posedge clk);
    write_reg(CFG_CORRECT_ENABLE, enable_data);
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int write_pct);
    repeat (count) send_beat(random_beat(write_pct));
  endtask

  initial begin
    int t;
    int p;
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 640 x 480, correction off
    send_beat(pixel(8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    for (t = 0; t < 3; t++) begin
      send_beat(table_write(2'(t), 8'h00, 8'hFF));
      send_beat(table_write(2'(t), 8'hFF, 8'h00));
      send_beat(table_write(2'(t), 8'h5A, 8'hA5));
    end
    send_beat(table_write(TABLE_NONE, 8'h33, 8'h77));

    // correction on with upper bits set; zero dimensions act as a 1 x 1 frame
    configure(13'h1FFF, 13'd0, 13'd0);
    send_beat(pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_beat(pixel(8'h00, 8'h00, 8'h00, 8'hFF));
    send_beat(pixel(8'h5A, 8'h5A, 8'h5A, 8'h80));

    // bit 0 clear turns correction off; oversize dimensions clamp
    configure(13'h1FFE, 13'h1FFF, 13'd4097);
    send_beat(pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C));

    // table write followed by a pixel that reads it, then finish a 3 x 2 frame
    configure(13'h0001, 13'd3, 13'd2);
    send_beat(table_write(TABLE_RED, 8'h10, 8'h3C));
    send_beat(pixel(8'h10, 8'h00, 8'hFF, 8'h01));
    repeat (5) send_beat(pixel(8'hFF, 8'h5A, 8'h00, 8'hFE));

    configure(13'h0001, 13'd1, 13'd1);
    run_phase(60, 20);
    configure(13'h0000, 13'd1, 13'd7);
    run_phase(60, 20);
    configure(13'h1001, 13'd9, 13'd1);
    run_phase(60, 20);
    configure(13'h0000, 13'd4096, 13'd4096);
    run_phase(40, 10);

    // square frame: the ramp climbs from every edge toward the middle
    configure(13'($urandom), 13'd30, 13'd30);
    run_phase(80, 3);
    steady = 1'b1;
    run_phase(250, 3);
    steady = 1'b0;
    run_phase(60, 3);
    hold_until_drained();
    run_phase(80, 3);

    for (p = 0; p < 6; p++) begin
      configure(13'($urandom), 13'($urandom_range(40, 1)), 13'($urandom_range(12, 1)));
      run_phase(40, 25);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_pixels.size() != 0) begin
      sb.errors++;
      $error("%0d pixels never produced a result", sb.pending_pixels.size());
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
